>>> design/tsag_pkg.sv
// ----------------------------------------------------------------------------
// tsag_pkg
// Shared codes and types for the subtree add / GCD query block.
// ----------------------------------------------------------------------------
`default_nettype none

package tsag_pkg;

   localparam int DATA_W = 32;

   // request codes
   localparam logic [2:0] REQ_LINK  = 3'd0;
   localparam logic [2:0] REQ_SET   = 3'd1;
   localparam logic [2:0] REQ_BUILD = 3'd2;
   localparam logic [2:0] REQ_ADD   = 3'd3;
   localparam logic [2:0] REQ_QUERY = 3'd4;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_ROOT      = 3'd1;
   localparam logic [2:0] ST_PARENTED  = 3'd2;
   localparam logic [2:0] ST_SELF      = 3'd3;
   localparam logic [2:0] ST_RANGE     = 3'd4;

   localparam logic [5:0] NODE_COUNT_RESET = 6'd32;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
   } gcd_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] result;
   } gcd_rsp_type;

endpackage

`default_nettype wire

>>> design/tsag_gcd.sv
// ----------------------------------------------------------------------------
// tsag_gcd
// Iterative Euclid GCD with a bit-serial truncating remainder, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tsag_gcd (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tsag_pkg::gcd_req_type gcd_req,
   output tsag_pkg::gcd_rsp_type     gcd_rsp
);
   import tsag_pkg::*;

   localparam logic [1:0] G_IDLE  = 2'd0;
   localparam logic [1:0] G_CHECK = 2'd1;
   localparam logic [1:0] G_DIV   = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [DATA_W-1:0] a_ff, a_in, b_ff, b_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] dvd_ff, dvd_in, dvs_ff, dvs_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [DATA_W:0]   rem_shift, rem_diff;
   logic [DATA_W-1:0] rem_step, rem_signed;

   // magnitude of a two's complement word, most negative stays as is
   function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] x);
      mag = x[DATA_W-1] ? (~x + 1'b1) : x;
   endfunction

   always_comb begin
      rem_shift = {rem_ff, dvd_ff[DATA_W-1]};
      rem_diff  = rem_shift - {1'b0, dvs_ff};
      // borrow out means the divisor did not fit
      if (rem_diff[DATA_W]) begin
         rem_step = rem_shift[DATA_W-1:0];
      end else begin
         rem_step = rem_diff[DATA_W-1:0];
      end
      // remainder takes the dividend's sign
      rem_signed = a_ff[DATA_W-1] ? (~rem_step + 1'b1) : rem_step;
   end

   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      dvs_in   = dvs_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         G_IDLE: begin
            if (gcd_req.start) begin
               a_in     = gcd_req.a;
               b_in     = gcd_req.b;
               state_in = G_CHECK;
            end
         end
         G_CHECK: begin
            if (b_ff == '0) begin
               done_in  = 1'b1;
               state_in = G_IDLE;
            end else begin
               dvd_in   = mag(a_ff);
               dvs_in   = mag(b_ff);
               rem_in   = '0;
               cnt_in   = '0;
               state_in = G_DIV;
            end
         end
         G_DIV: begin
            rem_in = rem_step;
            dvd_in = {dvd_ff[DATA_W-2:0], 1'b0};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               a_in     = b_ff;
               b_in     = rem_signed;
               state_in = G_CHECK;
            end
         end
         default: begin
            state_in = G_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= G_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign gcd_rsp.done   = done_ff;
   assign gcd_rsp.result = a_ff;

endmodule

`default_nettype wire

>>> design/tree_subtree_add_gcd_query.sv
// ----------------------------------------------------------------------------
// tree_subtree_add_gcd_query
// Rooted hierarchy with preorder numbering, subtree add and subtree GCD.
// ----------------------------------------------------------------------------
// Usage:
//  - Request beat: req_* fields are taken at a clock edge with start high and
//    busy low. busy stays high until the response beat has been issued.
//  - Response beat: rsp_valid is high for exactly one cycle with rsp_status
//    and rsp_gcd_result. The receiver cannot stall; it must take the beat.
//    The next request may start in the same cycle the response is shown.
//  - Config: csr_wr_en/csr_wr_data write node_count; write only while idle.
//  - Run time per request (n = nodes in use): add and query scan all n
//    nodes; a query also runs one GCD per member after the first, and
//    the GCD unit works out one remainder bit per cycle. Run time is set by
//    the single read port of each state memory and the bit-serial remainder
//    in the GCD unit.
//  - Reset: synchronous; link and number memories read as none/zero through
//    per-entry valid bits cleared at once, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module tree_subtree_add_gcd_query #(
   parameter int MAX_NODES = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [2:0]         req_type,
   input  wire logic [4:0]         req_parent_index,
   input  wire logic [4:0]         req_node_index,
   input  wire logic signed [31:0] req_value,
   output logic                    rsp_valid,
   output logic [2:0]              rsp_status,
   output logic signed [31:0]      rsp_gcd_result,
   input  wire logic               csr_wr_en,
   input  wire logic [5:0]         csr_wr_data
);
   import tsag_pkg::*;

   localparam int IW   = $clog2(MAX_NODES);      // node index width
   localparam int NCW  = $clog2(MAX_NODES + 1);
   localparam int CMPW = (NCW > 6) ? NCW : 6;    // node count compare width

   // control states
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_LINK_RD  = 4'd1;
   localparam logic [3:0] S_LINK_WR  = 4'd2;
   localparam logic [3:0] S_TGT_RD   = 4'd3;
   localparam logic [3:0] S_TGT_WAIT = 4'd4;
   localparam logic [3:0] S_SCAN_RD  = 4'd5;
   localparam logic [3:0] S_SCAN_CHK = 4'd6;
   localparam logic [3:0] S_GCD_WAIT = 4'd7;
   localparam logic [3:0] S_B_RD     = 4'd8;
   localparam logic [3:0] S_B_VISIT  = 4'd9;
   localparam logic [3:0] S_B_POP    = 4'd10;
   localparam logic [3:0] S_B_CLIMB  = 4'd11;

   // ---------------- control registers ----------------
   logic [3:0]        state_ff, state_in;
   logic [2:0]        typ_ff, typ_in;
   logic [IW-1:0]     m_ff, m_in, e_ff, e_in, v_ff, v_in;
   logic [DATA_W-1:0] val_ff, val_in, res_ff, res_in;
   logic [CMPW-1:0]   n_ff, n_in, cnt_ff, cnt_in;
   logic [2:0]        status_ff, status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0]     lo_ff, lo_in, hi_ff, hi_in;
   logic [IW:0]       sp_ff, sp_in, wc_ff, wc_in, guard_ff, guard_in;
   logic [5:0]        node_count_ff, node_count_in;

   // ---------------- memories ----------------
   // link memories: first child, last child, next sibling; a parent link
   // only matters as present or absent, so it lives in its written flags
   logic [IW-1:0]        fc_mem  [MAX_NODES];
   logic [IW-1:0]        lc_mem  [MAX_NODES];
   logic [IW-1:0]        ns_mem  [MAX_NODES];
   logic [DATA_W-1:0]    val_mem [MAX_NODES];
   logic [IW-1:0]        ent_mem [MAX_NODES];
   logic [IW-1:0]        ext_mem [MAX_NODES];
   logic [IW-1:0]        stk_mem [MAX_NODES];

   // per-entry written flags; unwritten links read as none, numbers as zero
   logic [MAX_NODES-1:0] par_vld_ff, fc_vld_ff, lc_vld_ff, ns_vld_ff;
   logic [MAX_NODES-1:0] val_vld_ff, ent_vld_ff, ext_vld_ff;

   logic              par_we, fc_we, lc_we, ns_we, val_we, ent_we, ext_we, stk_we;
   logic [IW-1:0]     par_wa, fc_wa, lc_wa, ns_wa, val_wa, ent_wa, ext_wa, stk_wa;
   logic [IW-1:0]     fc_wd, lc_wd, ns_wd, ent_wd, ext_wd, stk_wd;
   logic [DATA_W-1:0] val_wd;
   logic [IW-1:0]     par_ra, fc_ra, lc_ra, ns_ra, val_ra, ent_ra, ext_ra, stk_ra;

   logic [IW-1:0]     fc_rd_ff, lc_rd_ff, ns_rd_ff, ent_rd_ff, ext_rd_ff;
   logic [IW-1:0]     stk_rd_ff;
   logic [DATA_W-1:0] val_rd_ff;
   logic              par_rv_ff, fc_rv_ff, lc_rv_ff, ns_rv_ff, val_rv_ff, ent_rv_ff;
   logic              ext_rv_ff;

   // ---------------- GCD unit ----------------
   gcd_req_type gcd_req;
   gcd_rsp_type gcd_rsp;

   tsag_gcd u_gcd (
      .clock   (clock),
      .reset   (reset),
      .gcd_req (gcd_req),
      .gcd_rsp (gcd_rsp)
   );

   // ---------------- derived values ----------------
   logic [CMPW-1:0]   nc_ext, nuse;
   logic              oor_m, oor_e, in_rng;
   logic [IW-1:0]     ent_q, ext_q;
   logic [DATA_W-1:0] val_q;
   logic [IW:0]       guard_inc, wc_dec;

   always_comb begin
      nc_ext = CMPW'(node_count_ff);
      if (nc_ext == '0) begin
         nuse = CMPW'(1);
      end else if (nc_ext > CMPW'(MAX_NODES)) begin
         nuse = CMPW'(MAX_NODES);
      end else begin
         nuse = nc_ext;
      end
      oor_m     = CMPW'(req_parent_index) >= nuse;
      oor_e     = CMPW'(req_node_index) >= nuse;
      ent_q     = ent_rv_ff ? ent_rd_ff : '0;
      ext_q     = ext_rv_ff ? ext_rd_ff : '0;
      val_q     = val_rv_ff ? val_rd_ff : '0;
      in_rng    = (ent_q >= lo_ff) && (ent_q <= hi_ff);
      guard_inc = guard_ff + (IW+1)'(1);
      wc_dec    = wc_ff - (IW+1)'(1);
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in      = state_ff;
      typ_in        = typ_ff;
      m_in          = m_ff;
      e_in          = e_ff;
      v_in          = v_ff;
      val_in        = val_ff;
      res_in        = res_ff;
      n_in          = n_ff;
      cnt_in        = cnt_ff;
      status_in     = status_ff;
      rsp_valid_in  = 1'b0;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      sp_in         = sp_ff;
      wc_in         = wc_ff;
      guard_in      = guard_ff;
      node_count_in = csr_wr_en ? csr_wr_data : node_count_ff;

      par_we = 1'b0; par_wa = e_ff;
      fc_we  = 1'b0; fc_wa  = m_ff;  fc_wd  = e_ff;
      lc_we  = 1'b0; lc_wa  = m_ff;  lc_wd  = e_ff;
      ns_we  = 1'b0; ns_wa  = lc_rd_ff; ns_wd = e_ff;
      val_we = 1'b0; val_wa = cnt_ff[IW-1:0]; val_wd = val_q + val_ff;
      ent_we = 1'b0; ent_wa = v_ff;  ent_wd = wc_ff[IW-1:0];
      ext_we = 1'b0; ext_wa = v_ff;  ext_wd = wc_ff[IW-1:0];
      stk_we = 1'b0; stk_wa = sp_ff[IW-1:0]; stk_wd = v_ff;

      par_ra = e_ff;
      lc_ra  = m_ff;
      fc_ra  = v_ff;
      ns_ra  = v_ff;
      val_ra = cnt_ff[IW-1:0];
      ent_ra = cnt_ff[IW-1:0];
      ext_ra = e_ff;
      stk_ra = wc_dec[IW-1:0];

      gcd_req.start = 1'b0;
      gcd_req.a     = res_ff;
      gcd_req.b     = val_q;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               typ_in    = req_type;
               m_in      = IW'(req_parent_index);
               e_in      = IW'(req_node_index);
               val_in    = req_value;
               res_in    = '0;
               status_in = ST_OK;
               n_in      = nuse;
               priority if (req_type == REQ_LINK) begin
                  if (oor_m || oor_e) begin
                     status_in    = ST_RANGE;
                     rsp_valid_in = 1'b1;
                  end else if (req_node_index == 5'd0) begin
                     status_in    = ST_ROOT;
                     rsp_valid_in = 1'b1;
                  end else begin
                     state_in = S_LINK_RD;
                  end
               end else if (req_type == REQ_SET) begin
                  if (oor_e) begin
                     status_in = ST_RANGE;
                  end else begin
                     val_we = 1'b1;
                     val_wa = IW'(req_node_index);
                     val_wd = req_value;
                  end
                  rsp_valid_in = 1'b1;
               end else if (req_type == REQ_BUILD) begin
                  v_in     = '0;
                  sp_in    = '0;
                  wc_in    = '0;
                  guard_in = '0;
                  state_in = S_B_RD;
               end else if (req_type == REQ_ADD || req_type == REQ_QUERY) begin
                  if (oor_e) begin
                     status_in    = ST_RANGE;
                     rsp_valid_in = 1'b1;
                  end else begin
                     state_in = S_TGT_RD;
                  end
               end else begin
                  rsp_valid_in = 1'b1;   // unused code, plain ok
               end
            end
         end

         S_LINK_RD: begin
            state_in = S_LINK_WR;     // parent[e], last_child[m] in flight
         end

         S_LINK_WR: begin
            if (par_rv_ff) begin
               status_in = ST_PARENTED;
            end else if (m_ff == e_ff) begin
               status_in = ST_SELF;
            end else begin
               par_we = 1'b1;
               lc_we  = 1'b1;
               if (lc_rv_ff) begin
                  ns_we = 1'b1;       // append after current last child
               end else begin
                  fc_we = 1'b1;
               end
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end

         S_TGT_RD: begin
            ent_ra   = e_ff;
            state_in = S_TGT_WAIT;
         end

         S_TGT_WAIT: begin
            lo_in    = ent_q;
            hi_in    = ext_q;
            cnt_in   = '0;
            state_in = S_SCAN_RD;
         end

         S_SCAN_RD: begin
            if (cnt_ff < n_ff) begin
               state_in = S_SCAN_CHK;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         S_SCAN_CHK: begin
            state_in = S_SCAN_RD;
            cnt_in   = cnt_ff + CMPW'(1);
            if (in_rng) begin
               if (typ_ff == REQ_ADD) begin
                  val_we = 1'b1;
               end else if (res_ff == '0) begin
                  res_in = val_q;     // fold restarts on a zero
               end else begin
                  gcd_req.start = 1'b1;
                  cnt_in        = cnt_ff;
                  state_in      = S_GCD_WAIT;
               end
            end
         end

         S_GCD_WAIT: begin
            if (gcd_rsp.done) begin
               res_in   = gcd_rsp.result;
               cnt_in   = cnt_ff + CMPW'(1);
               state_in = S_SCAN_RD;
            end
         end

         S_B_RD: begin
            state_in = S_B_VISIT;     // first_child[v], next_sibling[v]
         end

         S_B_VISIT: begin
            ent_we   = 1'b1;
            wc_in    = wc_ff + (IW+1)'(1);
            guard_in = guard_inc;
            if (fc_rv_ff && (sp_ff < (IW+1)'(MAX_NODES))) begin
               stk_we = 1'b1;
               sp_in  = sp_ff + (IW+1)'(1);
               v_in   = fc_rd_ff;
               if (guard_inc < (IW+1)'(MAX_NODES)) begin
                  state_in = S_B_RD;
               end else begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               ext_we = 1'b1;         // leaf: exit equals its own entry
               if (ns_rv_ff) begin
                  v_in = ns_rd_ff;
                  if (guard_inc < (IW+1)'(MAX_NODES)) begin
                     state_in = S_B_RD;
                  end else begin
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end
               end else if (sp_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  sp_in    = sp_ff - (IW+1)'(1);
                  stk_ra   = sp_in[IW-1:0];
                  state_in = S_B_POP;
               end
            end
         end

         S_B_POP: begin
            v_in     = stk_rd_ff;
            ext_we   = 1'b1;
            ext_wa   = stk_rd_ff;
            ext_wd   = wc_dec[IW-1:0];
            ns_ra    = stk_rd_ff;
            state_in = S_B_CLIMB;
         end

         S_B_CLIMB: begin
            if (ns_rv_ff) begin
               v_in = ns_rd_ff;
               if (guard_ff < (IW+1)'(MAX_NODES)) begin
                  state_in = S_B_RD;
               end else begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end else if (sp_ff == '0) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               sp_in    = sp_ff - (IW+1)'(1);
               stk_ra   = sp_in[IW-1:0];
               state_in = S_B_POP;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         node_count_ff <= NODE_COUNT_RESET;
         sp_ff         <= '0;
         wc_ff         <= '0;
         guard_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         node_count_ff <= node_count_in;
         sp_ff         <= sp_in;
         wc_ff         <= wc_in;
         guard_ff      <= guard_in;
      end
   end

   always_ff @(posedge clock) begin
      typ_ff    <= typ_in;
      m_ff      <= m_in;
      e_ff      <= e_in;
      v_ff      <= v_in;
      val_ff    <= val_in;
      res_ff    <= res_in;
      n_ff      <= n_in;
      cnt_ff    <= cnt_in;
      status_ff <= status_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
   end

   // ---------------- memory arrays, one write and one read port each ----------------
   always_ff @(posedge clock) begin
      if (fc_we)  fc_mem[fc_wa]   <= fc_wd;
      if (lc_we)  lc_mem[lc_wa]   <= lc_wd;
      if (ns_we)  ns_mem[ns_wa]   <= ns_wd;
      if (val_we) val_mem[val_wa] <= val_wd;
      if (ent_we) ent_mem[ent_wa] <= ent_wd;
      if (ext_we) ext_mem[ext_wa] <= ext_wd;
      if (stk_we) stk_mem[stk_wa] <= stk_wd;
      fc_rd_ff  <= fc_mem[fc_ra];
      lc_rd_ff  <= lc_mem[lc_ra];
      ns_rd_ff  <= ns_mem[ns_ra];
      val_rd_ff <= val_mem[val_ra];
      ent_rd_ff <= ent_mem[ent_ra];
      ext_rd_ff <= ext_mem[ext_ra];
      stk_rd_ff <= stk_mem[stk_ra];
   end

   // written flags, cleared together at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         par_vld_ff <= '0;
         fc_vld_ff  <= '0;
         lc_vld_ff  <= '0;
         ns_vld_ff  <= '0;
         val_vld_ff <= '0;
         ent_vld_ff <= '0;
         ext_vld_ff <= '0;
         par_rv_ff  <= 1'b0;
         fc_rv_ff   <= 1'b0;
         lc_rv_ff   <= 1'b0;
         ns_rv_ff   <= 1'b0;
         val_rv_ff  <= 1'b0;
         ent_rv_ff  <= 1'b0;
         ext_rv_ff  <= 1'b0;
      end else begin
         if (par_we) par_vld_ff[par_wa] <= 1'b1;
         if (fc_we)  fc_vld_ff[fc_wa]   <= 1'b1;
         if (lc_we)  lc_vld_ff[lc_wa]   <= 1'b1;
         if (ns_we)  ns_vld_ff[ns_wa]   <= 1'b1;
         if (val_we) val_vld_ff[val_wa] <= 1'b1;
         if (ent_we) ent_vld_ff[ent_wa] <= 1'b1;
         if (ext_we) ext_vld_ff[ext_wa] <= 1'b1;
         par_rv_ff <= par_vld_ff[par_ra];
         fc_rv_ff  <= fc_vld_ff[fc_ra];
         lc_rv_ff  <= lc_vld_ff[lc_ra];
         ns_rv_ff  <= ns_vld_ff[ns_ra];
         val_rv_ff <= val_vld_ff[val_ra];
         ent_rv_ff <= ent_vld_ff[ent_ra];
         ext_rv_ff <= ext_vld_ff[ext_ra];
      end
   end

   // ---------------- outputs ----------------
   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_gcd_result = res_ff;

   // ---------------- assertions ----------------
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(!reset) |-> $past(busy) || $past(start))
      else $error("response beat without a request");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_gcd_result == '0))
      else $error("error response carries nonzero result");

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= (IW+1)'(MAX_NODES))
      else $error("walk stack overflow");

   a_gcd_from_scan: assert property (@(posedge clock) disable iff (reset)
      gcd_req.start |-> (state_ff == S_SCAN_CHK) && (typ_ff == REQ_QUERY))
      else $error("GCD started outside query scan");

   a_gcd_done_wait: assert property (@(posedge clock) disable iff (reset)
      gcd_req.start |=> (state_ff == S_GCD_WAIT))
      else $error("sequencer not waiting on GCD");

endmodule

`default_nettype wire
